/* hw/rtl/ssm_pkg.sv */
// Shared types and constants for the substring search matcher.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ssm_pkg;

	localparam int BYTE_W    = 8;
	localparam int POS_W     = 32;
	localparam int LEN_W     = 5;
	localparam int REG_W     = 64;
	localparam int PAT_BYTES = 16;
	localparam int PAT_IDX_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd2;

	// One text beat as held in the input stage
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} ssm_beat_t;

	// Outcome of comparing one beat against the pattern
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] start;
	} ssm_result_t;

endpackage

`default_nettype wire

/* hw/rtl/substring_search_matcher_core.sv */
// Substring search matcher: finds every occurrence, overlapping ones
// included, of a pattern of up to 16 bytes in a byte stream. One text byte
// is taken per beat and one result beat is returned for it; the block
// sustains one byte per cycle while out_ready stays high. A byte is held
// in the input register and its result beat in the result register; the
// single-pass compare of the new byte and the shift-register history
// against the whole pattern sits between them. A result flags
// a match ending at its byte and gives the offset of the match's first byte,
// saturating at all ones. A byte marked last closes the text; offsets
// restart at zero on the next byte. An empty pattern matches at offset zero
// on the first byte of each text. Write the pattern registers only while
// the block is idle. Depends on ssm_pkg, ssm_history and ssm_compare.
`default_nettype none

module substring_search_matcher_core #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [ssm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssm_pkg::REG_W-1:0]       cfg_wdata,
	// text input
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ssm_pkg::BYTE_W-1:0]      text_byte,
	input  logic                            is_last,
	// result output
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            match_found,
	output logic [ssm_pkg::POS_W-1:0]       match_start,
	output logic                            end_of_text
);
	import ssm_pkg::*;

	localparam int HIST_DEPTH = MAX_PATTERN - 1;
	localparam int SEEN_W     = $clog2(MAX_PATTERN + 1);

	// configuration registers
	logic [REG_W-1:0] pat_lo_q;
	logic [REG_W-1:0] pat_hi_q;
	logic [LEN_W-1:0] pat_len_q;

	// input stage
	ssm_beat_t beat_s1;
	logic      valid_s1;

	// result register
	logic             out_valid_q;
	logic             found_q;
	logic [POS_W-1:0] start_q;
	logic             last_q;

	logic              advance;
	ssm_result_t       result;
	logic [BYTE_W-1:0] recent [HIST_DEPTH];
	logic [POS_W-1:0]  pos;
	logic [SEEN_W-1:0] seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAT_LO:  pat_lo_q  <= cfg_wdata;
				CFG_PAT_HI:  pat_hi_q  <= cfg_wdata;
				CFG_PAT_LEN: pat_len_q <= cfg_wdata[LEN_W-1:0];
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	// Move the held beat into the result register whenever that register is
	// empty or being drained; history state steps at the same edge.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	// Take a new beat while the input stage is empty or being emptied, so a
	// stalled result still leaves room for one more byte.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1.data <= text_byte;
			beat_s1.last <= is_last;
		end
	end

	ssm_history #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_history (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.beat    (beat_s1),
		.recent  (recent),
		.pos     (pos),
		.seen    (seen)
	);

	ssm_compare #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_compare (
		.pat_lo  (pat_lo_q),
		.pat_hi  (pat_hi_q),
		.pat_len (pat_len_q),
		.beat    (beat_s1),
		.recent  (recent),
		.pos     (pos),
		.seen    (seen),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result payload until the next beat replaces it
	always_ff @(posedge clk) begin
		if (advance) begin
			found_q <= result.found;
			start_q <= result.start;
			last_q  <= beat_s1.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign match_found = found_q;
	assign match_start = start_q;
	assign end_of_text = last_q;

endmodule

`default_nettype wire

/* hw/rtl/ssm_history.sv */
// Text history for the substring search matcher: recent-byte shift register,
// text offset and per-text byte count. Depends on ssm_pkg.
`default_nettype none

module ssm_history #(
	parameter int MAX_PATTERN = 16,
	localparam int HIST_DEPTH = MAX_PATTERN - 1,
	localparam int SEEN_W     = $clog2(MAX_PATTERN + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  ssm_pkg::ssm_beat_t           beat,
	output logic [ssm_pkg::BYTE_W-1:0]   recent [HIST_DEPTH],
	output logic [ssm_pkg::POS_W-1:0]    pos,
	output logic [SEEN_W-1:0]            seen
);
	import ssm_pkg::*;

	localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_PATTERN);

	logic [BYTE_W-1:0] recent_q [HIST_DEPTH];
	logic [POS_W-1:0]  pos_q;
	logic [SEEN_W-1:0] seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				recent_q[i] <= '0;
			end
			pos_q  <= '0;
			seen_q <= '0;
		end else if (advance) begin
			if (beat.last) begin
				// new text starts at offset zero; history is left as it is
				pos_q  <= '0;
				seen_q <= '0;
			end else begin
				for (int i = HIST_DEPTH - 1; i > 0; i--) begin
					recent_q[i] <= recent_q[i-1];
				end
				recent_q[0] <= beat.data;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
				if (seen_q < SEEN_MAX) begin
					seen_q <= seen_q + SEEN_W'(1);
				end
			end
		end
	end

	assign recent = recent_q;
	assign pos    = pos_q;
	assign seen   = seen_q;

endmodule

`default_nettype wire

/* hw/rtl/ssm_compare.sv */
// Parallel pattern compare for the substring search matcher: aligns the
// current byte and history against the pattern. Depends on ssm_pkg.
`default_nettype none

module ssm_compare #(
	parameter int MAX_PATTERN = 16,
	localparam int HIST_DEPTH = MAX_PATTERN - 1,
	localparam int SEEN_W     = $clog2(MAX_PATTERN + 1)
) (
	input  logic [ssm_pkg::REG_W-1:0]   pat_lo,
	input  logic [ssm_pkg::REG_W-1:0]   pat_hi,
	input  logic [ssm_pkg::LEN_W-1:0]   pat_len,
	input  ssm_pkg::ssm_beat_t          beat,
	input  logic [ssm_pkg::BYTE_W-1:0]  recent [HIST_DEPTH],
	input  logic [ssm_pkg::POS_W-1:0]   pos,
	input  logic [SEEN_W-1:0]           seen,
	output ssm_pkg::ssm_result_t        result
);
	import ssm_pkg::*;

	localparam int CMP_N = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
	localparam logic [LEN_W-1:0] CMP_N_L = LEN_W'(CMP_N);
	localparam int CW = (SEEN_W + 1 > LEN_W) ? SEEN_W + 1 : LEN_W;

	logic [2*REG_W-1:0] pat_all;
	logic [LEN_W-1:0]   len_eff;
	logic [CW-1:0]      have;
	logic               enough;
	logic [CMP_N-1:0]   byte_ok;

	assign pat_all = {pat_hi, pat_lo};
	// clamp lengths beyond what the pattern registers and history support
	assign len_eff = (pat_len > CMP_N_L) ? CMP_N_L : pat_len;
	assign have    = CW'(seen) + CW'(1);
	assign enough  = have >= CW'(len_eff);

	// Slot j holds the byte j places back from the current one; it must equal
	// pattern byte len-1-j, or lie beyond the pattern.
	for (genvar j = 0; j < CMP_N; j++) begin : g_slot
		logic [LEN_W-1:0]     idx_full;
		logic [PAT_IDX_W-1:0] sel;
		logic [BYTE_W-1:0]    cand;

		assign idx_full = len_eff - LEN_W'(j) - LEN_W'(1);
		assign sel      = idx_full[PAT_IDX_W-1:0];
		if (j == 0) begin : g_cur
			assign cand = beat.data;
		end else begin : g_hist
			assign cand = recent[j-1];
		end
		assign byte_ok[j] = (LEN_W'(j) >= len_eff) ||
			(cand == pat_all[{sel, 3'b000} +: BYTE_W]);
	end

	always_comb begin
		result.found = 1'b0;
		result.start = '0;
		if (len_eff == '0) begin
			result.found = (pos == '0);
		end else if (enough && (&byte_ok)) begin
			result.found = 1'b1;
			if (pos == POS_MAX) begin
				result.start = POS_MAX;
			end else begin
				result.start = pos - POS_W'(len_eff) + POS_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* verif/tb_substring_search_matcher_core.sv */
// Self-checking testbench for substring_search_matcher_core: drives text beats,
// programs the pattern registers between phases and scores every result beat.
// Depends on ssm_pkg and the matcher RTL only.
`default_nettype none

module tb_substring_search_matcher_core;
	import ssm_pkg::*;

	localparam int MAX_PAT      = 16;
	localparam int HIST         = MAX_PAT - 1;
	localparam int N_ITEMS      = 1650;
	localparam int DRAIN_CYCLES = 8;
	localparam int RUN_LIMIT    = 1_600_000;

	// One result beat as the block should produce it
	typedef struct packed {
		ssm_result_t hit;
		logic        eot;
	} hit_beat_t;

	// Tracks pattern registers and text history, predicts one result per byte
	// and scores result beats in order against those predictions.
	class match_scoreboard;
		logic [8*PAT_BYTES-1:0] pat_bits;
		logic [LEN_W-1:0]       pat_len;
		logic [BYTE_W-1:0]      recent [HIST];
		logic [POS_W-1:0]       text_pos;
		int unsigned            seen;
		hit_beat_t              pending_q[$];
		int                     errors;
		int                     checked;

		function new();
			pat_bits = '0;
			pat_len  = LEN_W'(1);
			foreach (recent[i]) recent[i] = '0;
			text_pos = '0;
			seen     = 0;
			errors   = 0;
			checked  = 0;
		endfunction

		function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
			case (idx)
				CFG_PAT_LO:  pat_bits[63:0]   = data;
				CFG_PAT_HI:  pat_bits[127:64] = data;
				CFG_PAT_LEN: pat_len          = data[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function int outstanding();
			return pending_q.size();
		endfunction

		// Predict the result of one accepted byte, then advance the history
		function void note_beat(logic [BYTE_W-1:0] b, logic last);
			int unsigned len;
			int unsigned have;
			hit_beat_t   res;
			len = pat_len;
			if (len > MAX_PAT) len = MAX_PAT;
			if (len > PAT_BYTES) len = PAT_BYTES;
			have = seen + 1;
			res = '0;
			res.eot = last;
			if (len == 0) begin
				res.hit.found = (text_pos == '0);
			end else if (have >= len && b == pat_bits[8*(len-1) +: 8]) begin
				res.hit.found = 1'b1;
				for (int k = 1; k < len; k++) begin
					if (k - 1 >= HIST || recent[k-1] != pat_bits[8*(len-1-k) +: 8])
						res.hit.found = 1'b0;
				end
				if (res.hit.found)
					res.hit.start = (text_pos == POS_MAX) ? POS_MAX : text_pos - POS_W'(len - 1);
			end
			pending_q.push_back(res);
			if (last) begin
				text_pos = '0;
				seen     = 0;
			end else begin
				for (int i = HIST - 1; i > 0; i--) recent[i] = recent[i-1];
				recent[0] = b;
				if (text_pos != POS_MAX) text_pos++;
				if (seen < MAX_PAT) seen++;
			end
		endfunction

		task report(input string msg);
			$display("MISMATCH at result %0d: %s", checked, msg);
			errors++;
		endtask

		task check_beat(input logic found, input logic [POS_W-1:0] start, input logic eot);
			hit_beat_t want;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected beat found=%0b start=%0d eot=%0b",
					found, start, eot));
			end else begin
				want = pending_q.pop_front();
				if (found !== want.hit.found)
					report($sformatf("match_found %0b, want %0b", found, want.hit.found));
				if (start !== want.hit.start)
					report($sformatf("match_start %0d, want %0d", start, want.hit.start));
				if (eot !== want.eot)
					report($sformatf("end_of_text %0b, want %0b", eot, want.eot));
			end
			checked++;
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic [BYTE_W-1:0]    text_byte;
	logic                 is_last;
	logic                 out_valid;
	logic                 out_ready;
	logic                 match_found;
	logic [POS_W-1:0]     match_start;
	logic                 end_of_text;

	match_scoreboard sb;

	// Stimulus-side copy of the programmed pattern, used to program the block and build texts
	logic [8*PAT_BYTES-1:0] cur_pat;
	int unsigned            cur_len;
	logic [REG_W-1:0]       len_word;
	logic [BYTE_W-1:0]      sym_a, sym_b;

	int items_sent;
	int send_idle_pct;
	int recv_stall_pct;

	substring_search_matcher_core #(
		.MAX_PATTERN(MAX_PAT)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.match_found(match_found),
		.match_start(match_start),
		.end_of_text(end_of_text)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: toggle ready at the falling edge with the current stall rate
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Score every result beat at the edge that moves it
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_beat(match_found, match_start, end_of_text);
	end

	// Hard stop in case the block hangs
	initial begin
		#(RUN_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// Present one text beat and hold it until accepted. Idle gaps go in
	// before valid rises, so valid never drops while a beat is waiting.
	task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last);
		if (items_sent < N_ITEMS / 3) begin
			send_idle_pct  = 18;
			recv_stall_pct = 55;
		end else if (items_sent < 2 * N_ITEMS / 3) begin
			send_idle_pct  = 55;
			recv_stall_pct = 18;
		end else begin
			send_idle_pct  = 0;
			recv_stall_pct = 0;
		end
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		is_last   <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(b, last);
		items_sent++;
	endtask

	// Drop valid, wait for every predicted beat, then let the pipe empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all three pattern registers back to back, then drop the enable
	task automatic program_pattern(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi,
			input logic [REG_W-1:0] len_data);
		logic [REG_W-1:0]     vals [3];
		logic [CFG_IDX_W-1:0] idxs [3];
		vals = '{lo, hi, len_data};
		idxs = '{CFG_PAT_LO, CFG_PAT_HI, CFG_PAT_LEN};
		for (int i = 0; i < 3; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idxs[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
			sb.load_reg(idxs[i], vals[i]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Choose a pattern for the next phase. Most use a two-symbol alphabet so
	// texts hit full, partial and overlapping occurrences; some use the all
	// zero / all one extremes or fully random bytes.
	task automatic pick_pattern();
		int unsigned mode;
		int unsigned sel;
		mode = $urandom_range(9);
		sym_a = BYTE_W'($urandom_range(255));
		sym_b = BYTE_W'($urandom_range(255));
		case (mode)
			0: cur_pat = '0;
			1: cur_pat = '1;
			2, 3: cur_pat = {$urandom(), $urandom(), $urandom(), $urandom()};
			default: begin
				for (int i = 0; i < PAT_BYTES; i++)
					cur_pat[8*i +: 8] = $urandom_range(1) ? sym_a : sym_b;
			end
		endcase
		if (mode < 4) sym_a = cur_pat[7:0];
		sel = $urandom_range(11);
		case (sel)
			0: cur_len = 0;
			1, 2: cur_len = PAT_BYTES;
			3: cur_len = 31;
			4: cur_len = $urandom_range(17, 30);
			5: cur_len = 1;
			6: cur_len = $urandom_range(9, 15);
			default: cur_len = $urandom_range(2, 8);
		endcase
		// upper data bits of the length write carry noise a third of the time
		len_word = ($urandom_range(2) == 0) ? {$urandom(), $urandom()} : '0;
		len_word[LEN_W-1:0] = LEN_W'(cur_len);
	endtask

	// Build one text: planted occurrences (some corrupted), alphabet bytes
	// and raw bytes, or pure noise; the final byte carries the last mark.
	task automatic send_text(input int n_bytes, input bit noisy);
		logic [BYTE_W-1:0] body[$];
		int                eff;
		eff = (cur_len > PAT_BYTES) ? PAT_BYTES : cur_len;
		while (body.size() < n_bytes) begin
			if (!noisy && eff > 0 && $urandom_range(99) < 30) begin
				for (int j = 0; j < eff; j++) body.push_back(cur_pat[8*j +: 8]);
				if ($urandom_range(4) == 0)
					body[body.size() - 1 - $urandom_range(eff - 1)] =
						BYTE_W'($urandom_range(255));
			end else if (!noisy && $urandom_range(99) < 70) begin
				body.push_back($urandom_range(1) ? sym_a : sym_b);
			end else begin
				body.push_back(BYTE_W'($urandom_range(255)));
			end
		end
		foreach (body[i]) send_beat(body[i], i == body.size() - 1);
	endtask

	initial begin
		int phase_end;
		int n;
		logic [REG_W-1:0] lo, hi;
		sb             = new();
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_PAT_LO;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		text_byte      = '0;
		is_last        = 1'b0;
		items_sent     = 0;
		send_idle_pct  = 18;
		recv_stall_pct = 55;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset pattern is one zero byte: zero is an ordinary byte that matches
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b1);

		// Empty pattern: hit at offset zero on the first byte of each text only
		settle();
		program_pattern('0, '0, '0);
		send_beat(8'h5A, 1'b0);
		send_beat(8'hA5, 1'b1);
		send_beat(8'h00, 1'b1);

		// Three equal bytes: too few bytes before the last mark, then overlaps
		settle();
		program_pattern(64'h616161, '1, 64'd3);
		send_beat(8'h61, 1'b0);
		send_beat(8'h61, 1'b1);
		repeat (3) send_beat(8'h61, 1'b0);
		send_beat(8'h61, 1'b1);

		// Oversized length clips to the full sixteen bytes
		settle();
		lo = {$urandom(), $urandom()};
		hi = {$urandom(), $urandom()};
		program_pattern(lo, hi, 64'd31);
		cur_pat = {hi, lo};
		for (int i = 0; i < PAT_BYTES; i++)
			send_beat(cur_pat[8*i +: 8], i == PAT_BYTES - 1);

		// Random phases, each with a fresh pattern programmed while idle
		while (items_sent < N_ITEMS) begin
			pick_pattern();
			settle();
			program_pattern(cur_pat[63:0], cur_pat[127:64], len_word);
			phase_end = items_sent + $urandom_range(40, 140);
			while (items_sent < phase_end) begin
				n = ($urandom_range(19) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 24);
				send_text(n, $urandom_range(99) < 15);
			end
		end

		settle();
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_history.sv
hw/rtl/ssm_compare.sv
hw/rtl/substring_search_matcher_core.sv
verif/tb_substring_search_matcher_core.sv
